@@ rtl/tbws_pkg.sv @@
// Shared types and default sizes for the tournament best/worst selector.
`timescale 1ns / 1ps
`default_nettype none

package tbws_pkg;

  localparam int FIT_W = 32;
  localparam int INDEX_W = 16;

  localparam int GROUP_SIZE_DEFAULT = 8;
  localparam int WINNER_COUNT_DEFAULT = 2;
  localparam int COPIES_PER_WINNER_DEFAULT = 2;

  typedef enum logic {
    OP_MEMBER = 1'b0,
    OP_END    = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     operation;
    logic signed [FIT_W-1:0] fitness;
    logic [INDEX_W-1:0]      member_index;
  } member_t;

  typedef struct packed {
    logic [INDEX_W-1:0] winner_index;
    logic [INDEX_W-1:0] loser_index;
    logic               last_pair;
  } pair_t;

endpackage

`default_nettype wire

@@ rtl/tournament_best_worst_selector_top.sv @@
// Top level of the tournament best/worst selector.
//
//   channel   direction  handshake                 beat
//   member    in         member_valid/member_stall  operation, fitness, member_index
//   pair      out        pair_valid/pair_stall      winner_index, loser_index, last_pair
//
// One member beat is taken per cycle while member_stall is low; both lists are
// updated in that cycle by a parallel compare-and-shift across all slots.
// The last member of a tournament places its winner and loser lists in a
// two-entry queue; the back end then sends WINNER_COUNT*COPIES_PER_WINNER pairs,
// one per cycle unless pair_stall holds them, through its output register.
// member_stall is high only while both queue entries hold unsent tournaments.
// Reset clears the tournament position, the queue and the output valid; the
// lists themselves need no clearing and there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module tournament_best_worst_selector_top #(
  parameter int GROUP_SIZE        = tbws_pkg::GROUP_SIZE_DEFAULT,
  parameter int WINNER_COUNT      = tbws_pkg::WINNER_COUNT_DEFAULT,
  parameter int COPIES_PER_WINNER = tbws_pkg::COPIES_PER_WINNER_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              member_valid,
  output logic                   member_stall,
  input  wire tbws_pkg::member_t member,
  output logic                   pair_valid,
  input  wire logic              pair_stall,
  output tbws_pkg::pair_t        pair
);
  import tbws_pkg::*;

  localparam int LOSER_COUNT = WINNER_COUNT * COPIES_PER_WINNER;

  logic q_full, q_valid, push, pop;
  logic [WINNER_COUNT-1:0][INDEX_W-1:0] push_best, head_best;
  logic [LOSER_COUNT-1:0][INDEX_W-1:0]  push_worst, head_worst;

  tbws_front #(
    .GROUP_SIZE        (GROUP_SIZE),
    .WINNER_COUNT      (WINNER_COUNT),
    .COPIES_PER_WINNER (COPIES_PER_WINNER)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .member_valid (member_valid),
    .member_stall (member_stall),
    .member       (member),
    .q_full       (q_full),
    .push         (push),
    .push_best    (push_best),
    .push_worst   (push_worst)
  );

  tbws_queue #(
    .WINNER_COUNT (WINNER_COUNT),
    .LOSER_COUNT  (LOSER_COUNT)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_best  (push_best),
    .push_worst (push_worst),
    .full       (q_full),
    .q_valid    (q_valid),
    .pop        (pop),
    .head_best  (head_best),
    .head_worst (head_worst)
  );

  tbws_back #(
    .WINNER_COUNT      (WINNER_COUNT),
    .COPIES_PER_WINNER (COPIES_PER_WINNER)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .pop        (pop),
    .head_best  (head_best),
    .head_worst (head_worst),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .pair       (pair)
  );

endmodule

`default_nettype wire

@@ rtl/tbws_front.sv @@
// Front end: tournament position and parallel insertion into the best and worst lists.
`timescale 1ns / 1ps
`default_nettype none

module tbws_front #(
  parameter int GROUP_SIZE        = tbws_pkg::GROUP_SIZE_DEFAULT,
  parameter int WINNER_COUNT      = tbws_pkg::WINNER_COUNT_DEFAULT,
  parameter int COPIES_PER_WINNER = tbws_pkg::COPIES_PER_WINNER_DEFAULT
) (
  input  wire logic                                                   clk,
  input  wire logic                                                   rst,
  input  wire logic                                                   member_valid,
  output logic                                                        member_stall,
  input  wire tbws_pkg::member_t                                      member,
  input  wire logic                                                   q_full,
  output logic                                                        push,
  output logic [WINNER_COUNT-1:0][tbws_pkg::INDEX_W-1:0]              push_best,
  output logic [WINNER_COUNT*COPIES_PER_WINNER-1:0][tbws_pkg::INDEX_W-1:0] push_worst
);
  import tbws_pkg::*;

  localparam int LOSER_COUNT = WINNER_COUNT * COPIES_PER_WINNER;
  localparam int POS_W = (GROUP_SIZE > 2) ? $clog2(GROUP_SIZE) : 1;

  logic [POS_W-1:0] pos;

  logic signed [FIT_W-1:0] best_fit [WINNER_COUNT];
  logic signed [FIT_W-1:0] best_fit_next [WINNER_COUNT];
  logic [WINNER_COUNT-1:0][INDEX_W-1:0] best_idx, best_idx_next;

  logic signed [FIT_W-1:0] worst_fit [LOSER_COUNT];
  logic signed [FIT_W-1:0] worst_fit_next [LOSER_COUNT];
  logic [LOSER_COUNT-1:0][INDEX_W-1:0] worst_idx, worst_idx_next;

  logic [WINNER_COUNT-1:0] bkeep;
  logic [LOSER_COUNT-1:0]  wkeep;
  logic first, best_fill, worst_fill, last, fire, member_beat;
  logic signed [FIT_W-1:0] fit;
  logic [INDEX_W-1:0] idx;

  assign member_stall = q_full;
  assign fire = member_valid && !member_stall;
  assign member_beat = fire && (member.operation == OP_MEMBER);
  assign fit = member.fitness;
  assign idx = member.member_index;
  assign first = (pos == '0);
  assign last = (32'(pos) == GROUP_SIZE - 1);
  assign best_fill = (32'(pos) < WINNER_COUNT);
  assign worst_fill = (32'(pos) < LOSER_COUNT);

  // A slot keeps its entry when the new member sorts behind it; the first slot
  // that does not keep takes the new member and the rest shift down by one.
  always_comb begin
    for (int k = 0; k < WINNER_COUNT; k++) begin
      if (best_fill) begin
        bkeep[k] = (k < 32'(pos)) && (best_fit[k] < fit);
      end else begin
        bkeep[k] = (best_fit[k] <= fit);
      end
    end
    for (int k = 0; k < LOSER_COUNT; k++) begin
      if (worst_fill) begin
        wkeep[k] = (k < 32'(pos)) && (worst_fit[k] >= fit);
      end else begin
        wkeep[k] = (worst_fit[k] > fit);
      end
    end

    best_fit_next[0] = bkeep[0] ? best_fit[0] : fit;
    best_idx_next[0] = bkeep[0] ? best_idx[0] : idx;
    for (int k = 1; k < WINNER_COUNT; k++) begin
      if (bkeep[k]) begin
        best_fit_next[k] = best_fit[k];
        best_idx_next[k] = best_idx[k];
      end else if (bkeep[k-1]) begin
        best_fit_next[k] = fit;
        best_idx_next[k] = idx;
      end else if (first) begin
        best_fit_next[k] = '0;
        best_idx_next[k] = '0;
      end else begin
        best_fit_next[k] = best_fit[k-1];
        best_idx_next[k] = best_idx[k-1];
      end
    end

    worst_fit_next[0] = wkeep[0] ? worst_fit[0] : fit;
    worst_idx_next[0] = wkeep[0] ? worst_idx[0] : idx;
    for (int k = 1; k < LOSER_COUNT; k++) begin
      if (wkeep[k]) begin
        worst_fit_next[k] = worst_fit[k];
        worst_idx_next[k] = worst_idx[k];
      end else if (wkeep[k-1]) begin
        worst_fit_next[k] = fit;
        worst_idx_next[k] = idx;
      end else if (first) begin
        worst_fit_next[k] = '0;
        worst_idx_next[k] = '0;
      end else begin
        worst_fit_next[k] = worst_fit[k-1];
        worst_idx_next[k] = worst_idx[k-1];
      end
    end
  end

  assign push = member_beat && last;
  assign push_best = best_idx_next;
  assign push_worst = worst_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (fire) begin
      if (member.operation == OP_END || last) begin
        pos <= '0;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (member_beat) begin
      best_fit <= best_fit_next;
      best_idx <= best_idx_next;
      worst_fit <= worst_fit_next;
      worst_idx <= worst_idx_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    32'(pos) < GROUP_SIZE)
    else $error("tournament position out of range");

endmodule

`default_nettype wire

@@ rtl/tbws_queue.sv @@
// Two-entry queue of finished tournament lists between front and back.
`timescale 1ns / 1ps
`default_nettype none

module tbws_queue #(
  parameter int WINNER_COUNT = tbws_pkg::WINNER_COUNT_DEFAULT,
  parameter int LOSER_COUNT  = tbws_pkg::WINNER_COUNT_DEFAULT
                               * tbws_pkg::COPIES_PER_WINNER_DEFAULT
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     push,
  input  wire logic [WINNER_COUNT-1:0][tbws_pkg::INDEX_W-1:0] push_best,
  input  wire logic [LOSER_COUNT-1:0][tbws_pkg::INDEX_W-1:0]  push_worst,
  output logic                                          full,
  output logic                                          q_valid,
  input  wire logic                                     pop,
  output logic [WINNER_COUNT-1:0][tbws_pkg::INDEX_W-1:0]      head_best,
  output logic [LOSER_COUNT-1:0][tbws_pkg::INDEX_W-1:0]       head_worst
);
  import tbws_pkg::*;

  localparam int Depth = 2;

  logic [WINNER_COUNT-1:0][INDEX_W-1:0] best_mem [Depth];
  logic [LOSER_COUNT-1:0][INDEX_W-1:0]  worst_mem [Depth];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'(Depth));
  assign q_valid = (count != 2'd0);
  assign head_best = best_mem[rd_ptr];
  assign head_worst = worst_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      best_mem[wr_ptr] <= push_best;
      worst_mem[wr_ptr] <= push_worst;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue read while empty");

endmodule

`default_nettype wire

@@ rtl/tbws_back.sv @@
// Back end: walks one queued tournament and sends its winner/loser pairs.
`timescale 1ns / 1ps
`default_nettype none

module tbws_back #(
  parameter int WINNER_COUNT      = tbws_pkg::WINNER_COUNT_DEFAULT,
  parameter int COPIES_PER_WINNER = tbws_pkg::COPIES_PER_WINNER_DEFAULT
) (
  input  wire logic                                                   clk,
  input  wire logic                                                   rst,
  input  wire logic                                                   q_valid,
  output logic                                                        pop,
  input  wire logic [WINNER_COUNT-1:0][tbws_pkg::INDEX_W-1:0]         head_best,
  input  wire logic [WINNER_COUNT*COPIES_PER_WINNER-1:0][tbws_pkg::INDEX_W-1:0] head_worst,
  output logic                                                        pair_valid,
  input  wire logic                                                   pair_stall,
  output tbws_pkg::pair_t                                             pair
);
  import tbws_pkg::*;

  localparam int LOSER_COUNT = WINNER_COUNT * COPIES_PER_WINNER;
  localparam int WIN_W = (WINNER_COUNT > 1) ? $clog2(WINNER_COUNT) : 1;
  localparam int COPY_W = (COPIES_PER_WINNER > 1) ? $clog2(COPIES_PER_WINNER) : 1;
  localparam int LOSE_W = (LOSER_COUNT > 1) ? $clog2(LOSER_COUNT) : 1;

  logic [WIN_W-1:0]  win_i;
  logic [COPY_W-1:0] copy_c;
  logic [LOSE_W-1:0] lose_i;
  logic load, last, last_copy;

  assign load = q_valid && (!pair_valid || !pair_stall);
  assign last = (32'(lose_i) == LOSER_COUNT - 1);
  assign last_copy = (32'(copy_c) == COPIES_PER_WINNER - 1);
  // The entry leaves the queue as its final pair moves into the output register.
  assign pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_i <= '0;
      copy_c <= '0;
      lose_i <= '0;
      pair_valid <= 1'b0;
    end else begin
      if (load) begin
        pair_valid <= 1'b1;
        if (last) begin
          win_i <= '0;
          copy_c <= '0;
          lose_i <= '0;
        end else begin
          lose_i <= lose_i + LOSE_W'(1);
          if (last_copy) begin
            copy_c <= '0;
            win_i <= win_i + WIN_W'(1);
          end else begin
            copy_c <= copy_c + COPY_W'(1);
          end
        end
      end else if (!pair_stall) begin
        pair_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pair.winner_index <= head_best[win_i];
      pair.loser_index <= head_worst[lose_i];
      pair.last_pair <= last;
    end
  end

  a_counters_agree: assert property (@(posedge clk) disable iff (rst)
    32'(lose_i) == 32'(win_i) * COPIES_PER_WINNER + 32'(copy_c))
    else $error("winner and loser counters out of step");

  a_copy_range: assert property (@(posedge clk) disable iff (rst)
    32'(copy_c) < COPIES_PER_WINNER && 32'(win_i) < WINNER_COUNT)
    else $error("pair counter out of range");

endmodule

`default_nettype wire

@@ tb/tb_tournament_best_worst_selector_top.sv @@
// Self-checking testbench for the tournament best/worst selector: directed table, then random.
`timescale 1ns / 1ps

module tb_tournament_best_worst_selector_top;
  import tbws_pkg::*;

  localparam int GROUP = GROUP_SIZE_DEFAULT;
  localparam int WINNERS = WINNER_COUNT_DEFAULT;
  localparam int COPIES = COPIES_PER_WINNER_DEFAULT;
  localparam int LOSERS = WINNERS * COPIES;
  localparam int DIR_ROWS = 25;
  localparam int RANDOM_MEMBERS = 200;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [FIT_W-1:0] FIT_MIN = 32'sh8000_0000;
  localparam logic signed [FIT_W-1:0] FIT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FIT_W-1:0] FIT_ONE = 32'sh0001_0000;

  typedef struct packed {
    member_t            beat;
    logic               typed;
    pair_t [LOSERS-1:0] pairs;
  } dir_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    member_valid = 1'b0;
  logic    member_stall;
  member_t member = '0;
  logic    pair_valid;
  logic    pair_stall = 1'b0;
  pair_t   pair;

  // Slot row 0 holds the winners (lowest fitness first), row 1 the losers (highest first).
  logic signed [FIT_W-1:0] rank_fit [2][LOSERS];
  logic [INDEX_W-1:0]      rank_idx [2][LOSERS];
  int                      tour_pos = 0;
  pair_t                   tour_pairs [LOSERS];
  pair_t                   expected_pairs [$];

  int mismatches = 0;
  int pairs_checked = 0;
  int members_sent = 0;
  int tournaments_done = 0;
  int partials_dropped = 0;
  int burst_left = 0;
  int cycles = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_mode_left = 0;

  tournament_best_worst_selector_top u_top (
    .clk          (clk),
    .rst          (rst),
    .member_valid (member_valid),
    .member_stall (member_stall),
    .member       (member),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .pair         (pair)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic dir_row_t mk_row(input op_t op, input logic [FIT_W-1:0] fit,
                                      input logic [INDEX_W-1:0] idx);
    dir_row_t r;
    r = '0;
    r.beat.operation = op;
    r.beat.fitness = fit;
    r.beat.member_index = idx;
    return r;
  endfunction

  function automatic pair_t mk_pair(input logic [INDEX_W-1:0] winner,
                                    input logic [INDEX_W-1:0] loser, input logic last);
    pair_t p;
    p.winner_index = winner;
    p.loser_index = loser;
    p.last_pair = last;
    return p;
  endfunction

  // Extremes and narrow ranges are weighted up so that ties happen often.
  function automatic logic signed [FIT_W-1:0] pick_fitness();
    logic signed [FIT_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = FIT_MIN;
      1: v = FIT_MAX;
      2: v = (int'($urandom_range(0, 6)) - 3) * FIT_ONE;
      3: v = int'($urandom_range(0, 6)) - 3;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic dir_row_t rand_row(input op_t op);
    return mk_row(op, pick_fitness(), INDEX_W'($urandom_range(0, 16'hFFFF)));
  endfunction

  task automatic rank_insert(input int list, input int used, input int cap, input int slot,
                             input logic signed [FIT_W-1:0] fit,
                             input logic [INDEX_W-1:0] idx);
    int k;
    if (slot < cap) begin
      k = (used < cap) ? used : cap - 1;
      while (k > slot) begin
        rank_fit[list][k] = rank_fit[list][k-1];
        rank_idx[list][k] = rank_idx[list][k-1];
        k--;
      end
      rank_fit[list][slot] = fit;
      rank_idx[list][slot] = idx;
    end
  endtask

  // Updates the tournament state for one accepted beat; a completed tournament
  // leaves its pairs in tour_pairs.
  task automatic predict_member(input member_t b, output int produced);
    logic signed [FIT_W-1:0] f;
    int j;
    produced = 0;
    if (b.operation == OP_END) begin
      if (tour_pos != 0) partials_dropped++;
      tour_pos = 0;
    end else begin
      f = b.fitness;
      if (tour_pos == 0) begin
        for (int i = 0; i < LOSERS; i++) begin
          rank_fit[0][i] = '0;
          rank_idx[0][i] = '0;
          rank_fit[1][i] = '0;
          rank_idx[1][i] = '0;
        end
      end
      // While filling, a new winner goes ahead of equals; once full, only a strictly
      // lower fitness gets in, and it lands behind equals.
      if (tour_pos < WINNERS) begin
        j = 0;
        while (j < tour_pos && rank_fit[0][j] < f) j++;
        rank_insert(0, tour_pos, WINNERS, j, f, b.member_index);
      end else begin
        j = WINNERS;
        while (j > 0 && f < rank_fit[0][j-1]) j--;
        rank_insert(0, WINNERS, WINNERS, j, f, b.member_index);
      end
      // Losers mirror this: behind equals while filling, ahead of equals once full.
      if (tour_pos < LOSERS) begin
        j = 0;
        while (j < tour_pos && rank_fit[1][j] >= f) j++;
        rank_insert(1, tour_pos, LOSERS, j, f, b.member_index);
      end else begin
        j = LOSERS;
        while (j > 0 && f >= rank_fit[1][j-1]) j--;
        rank_insert(1, LOSERS, LOSERS, j, f, b.member_index);
      end
      if (tour_pos + 1 < GROUP) begin
        tour_pos++;
      end else begin
        tour_pos = 0;
        tournaments_done++;
        for (int w = 0; w < LOSERS; w++) begin
          tour_pairs[w] = mk_pair(rank_idx[0][w / COPIES], rank_idx[1][w], w == LOSERS - 1);
        end
        produced = LOSERS;
      end
    end
  endtask

  // Offers one beat, holding it until accepted. Bursts of random length are
  // separated by random gaps with valid low.
  task automatic send_beat(input dir_row_t row);
    int    produced;
    pair_t next_pair;
    if (burst_left == 0) begin
      member_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    member <= row.beat;
    member_valid <= 1'b1;
    @(posedge clk);
    while (member_stall) @(posedge clk);
    if (row.beat.operation == OP_MEMBER) members_sent++;
    predict_member(row.beat, produced);
    for (int i = 0; i < produced; i++) begin
      next_pair = row.typed ? row.pairs[i] : tour_pairs[i];
      expected_pairs = {expected_pairs, next_pair};
    end
  endtask

  task automatic drain();
    member_valid <= 1'b0;
    do @(posedge clk); while (expected_pairs.size() != 0);
  endtask

  // Receiver: switches among no stall, light and heavy random stall, and serves
  // a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pair_stall <= 1'b1;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_mode_left = $urandom_range(5, 60);
      end
      stall_mode_left--;
      case (stall_mode)
        0: pair_stall <= 1'b0;
        1: pair_stall <= ($urandom_range(0, 3) == 0);
        default: pair_stall <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk) begin : pair_check
    pair_t want;
    if (!rst && pair_valid && !pair_stall) begin
      if (expected_pairs.size() == 0) begin
        mismatches++;
        $display("%0t: pair beat with none expected: winner %h loser %h last %b",
                 $time, pair.winner_index, pair.loser_index, pair.last_pair);
      end else begin
        want = expected_pairs.pop_front();
        pairs_checked++;
        if (pair.winner_index !== want.winner_index) begin
          mismatches++;
          $display("%0t: winner_index expected %h actual %h",
                   $time, want.winner_index, pair.winner_index);
        end
        if (pair.loser_index !== want.loser_index) begin
          mismatches++;
          $display("%0t: loser_index expected %h actual %h",
                   $time, want.loser_index, pair.loser_index);
        end
        if (pair.last_pair !== want.last_pair) begin
          mismatches++;
          $display("%0t: last_pair expected %b actual %b",
                   $time, want.last_pair, pair.last_pair);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pairs outstanding", cycles, expected_pairs.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_table [DIR_ROWS];
    int       target;
    int       n;
    bit       paused;

    paused = 1'b0;
    // End of population straight after reset: nothing to drop, no result.
    dir_table[0] = mk_row(OP_END, 32'hDEAD_BEEF, 16'hA5A5);
    // A tournament of extremes with ties on both lists.
    dir_table[1] = mk_row(OP_MEMBER, FIT_MAX, 16'hFFFF);
    dir_table[2] = mk_row(OP_MEMBER, FIT_MIN, 16'h0000);
    dir_table[3] = mk_row(OP_MEMBER, 32'h0000_0000, 16'h0002);
    dir_table[4] = mk_row(OP_MEMBER, 32'h0000_0000, 16'h0003);
    dir_table[5] = mk_row(OP_MEMBER, FIT_ONE, 16'h0004);
    dir_table[6] = mk_row(OP_MEMBER, -FIT_ONE, 16'h0005);
    dir_table[7] = mk_row(OP_MEMBER, FIT_MAX, 16'h0006);
    dir_table[8] = mk_row(OP_MEMBER, FIT_MIN, 16'h0007);
    dir_table[8].typed = 1'b1;
    dir_table[8].pairs[0] = mk_pair(16'h0000, 16'h0006, 1'b0);
    dir_table[8].pairs[1] = mk_pair(16'h0000, 16'hFFFF, 1'b0);
    dir_table[8].pairs[2] = mk_pair(16'h0007, 16'h0004, 1'b0);
    dir_table[8].pairs[3] = mk_pair(16'h0007, 16'h0002, 1'b1);
    // Seven members, then end of population drops the partial tournament.
    for (int i = 0; i < GROUP - 1; i++) begin
      dir_table[9 + i] = mk_row(OP_MEMBER, (i - 3) * FIT_ONE, INDEX_W'(16'h0100 + i));
    end
    dir_table[16] = mk_row(OP_END, 32'h1234_5678, 16'h5A5A);
    // A tournament where every fitness is equal.
    for (int i = 0; i < GROUP; i++) begin
      dir_table[17 + i] = mk_row(OP_MEMBER, 32'h0000_8000, INDEX_W'(16'h0020 + i));
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) send_beat(dir_table[i]);

    target = members_sent + RANDOM_MEMBERS;
    // The receiver holds off while the sender keeps offering whole tournaments,
    // so the pending queue fills and member_stall rises.
    hold_asks++;
    burst_left = 4 * GROUP + 1;
    repeat (4 * GROUP) send_beat(rand_row(OP_MEMBER));
    burst_left = 0;
    drain();

    while (members_sent < target) begin
      case ($urandom_range(0, 19))
        0: send_beat(rand_row(OP_END));
        1, 2: begin
          n = $urandom_range(1, GROUP - 1);
          repeat (n) send_beat(rand_row(OP_MEMBER));
          send_beat(rand_row(OP_END));
        end
        default: repeat (GROUP) send_beat(rand_row(OP_MEMBER));
      endcase
      if (!paused && members_sent >= target - RANDOM_MEMBERS / 2) begin
        paused = 1'b1;
        drain();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d members: %0d full tournaments, %0d partial ones dropped.",
             members_sent, tournaments_done, partials_dropped);
    $display("Checked %0d pair beats under random gaps, stalls and one long hold-off.",
             pairs_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tbws_pkg.sv
rtl/tbws_front.sv
rtl/tbws_queue.sv
rtl/tbws_back.sv
rtl/tournament_best_worst_selector_top.sv
tb/tb_tournament_best_worst_selector_top.sv
